[design/idcn_pkg.sv]
// ----------------------------------------------------------------------------
// idcn_pkg: shared types and constants for the I/Q DC removal, clipping and
// RMS normalization block.
// ----------------------------------------------------------------------------
`default_nettype none
package idcn_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PART_W   = 17;
  localparam int MAG_W    = 18;
  localparam int SUM_W    = 23;
  localparam int ENERGY_W = 42;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ARG_ERR  = 2'd1;
  localparam logic [1:0] STATUS_DATA_ERR = 2'd2;

  // One stored centered sample, imaginary part in the upper half.
  typedef struct packed {
    logic signed [PART_W-1:0] im;
    logic signed [PART_W-1:0] re;
  } iq_part_t;

  // Request and reply between the sequencer and the shared divider.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

  // Request and reply between the sequencer and the shared root unit.
  typedef struct packed {
    logic        start;
    logic [63:0] arg;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

endpackage : idcn_pkg
`default_nettype wire

[design/idcn_if.sv]
// ----------------------------------------------------------------------------
// idcn_in_if / idcn_out_if: valid/ready channels of the normalization block.
// A transaction completes on a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
`default_nettype none
interface idcn_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_re;
  logic signed [15:0] sample_im;
  logic               sample_invalid;
  logic               last_sample;
  modport source (output valid, sample_re, sample_im, sample_invalid, last_sample,
                  input ready);
  modport sink   (input valid, sample_re, sample_im, sample_invalid, last_sample,
                  output ready);
endinterface : idcn_in_if

interface idcn_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_re;
  logic signed [15:0] out_im;
  logic [1:0]         status;
  logic               last_out;
  modport source (output valid, out_re, out_im, status, last_out, input ready);
  modport sink   (input valid, out_re, out_im, status, last_out, output ready);
endinterface : idcn_out_if
`default_nettype wire

[design/idcn_ram.sv]
// ----------------------------------------------------------------------------
// idcn_ram: generic single-port synchronous RAM with a registered read.
// One write or one read per cycle; read data appears in the cycle after the address.
// ----------------------------------------------------------------------------
`default_nettype none
module idcn_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write-first is not needed: callers never read an address being written.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule : idcn_ram
`default_nettype wire

[design/idcn_div.sv]
// ----------------------------------------------------------------------------
// idcn_div: unsigned 64 by 64 bit restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module idcn_div
  import idcn_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [63:0] quo;
  logic [63:0] rem;
  logic [63:0] den;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [64:0] trial;

  // Shift in the next dividend bit and try subtracting the divisor.
  assign trial = {rem, quo[63]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo  <= req.num;
        rem  <= '0;
        den  <= req.den;
        cnt  <= 7'd64;
      end else if (busy) begin
        if (trial[64]) begin
          rem <= {rem[62:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end else begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule : idcn_div
`default_nettype wire

[design/idcn_sqrt.sv]
// ----------------------------------------------------------------------------
// idcn_sqrt: 64 bit integer square root, one result bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module idcn_sqrt
  import idcn_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire sqrt_req_t req,
  output sqrt_rsp_t      rsp
);

  logic [63:0] val;
  logic [63:0] res;
  logic [63:0] bitv;
  logic        busy;
  logic        done;
  logic [63:0] sum;

  assign sum = res + bitv;

  // Digit-by-digit root: each cycle decides one bit of the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        val  <= req.arg;
        res  <= '0;
        bitv <= 64'd1 << 62;
      end else if (busy) begin
        if (val >= sum) begin
          val <= val - sum;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.root = res[31:0];

endmodule : idcn_sqrt
`default_nettype wire

[design/iq_dc_clip_normalize.sv]
// ----------------------------------------------------------------------------
// iq_dc_clip_normalize: block DC removal, MAD clipping and RMS normalization.
//
// Samples arrive on the in channel, one transaction per sample, and are stored
// while the input is open (one per cycle). The transaction with last_sample
// set closes the block; the input then stays closed while the block is worked
// on. The work centers the samples, takes magnitudes with a shared bit-serial
// root unit, sorts the magnitudes and the deviations with an insertion sort in
// the sort RAM, clips with the shared divider, and divides each part by the
// RMS on the out channel. The results of a block leave one per transaction on
// the out channel. A block with more than MAX_BLOCK samples, or with no
// energy, gives one result with an error status. Out valid holds while the
// receiver stalls; the block waits. Reset clears the count, sums and
// sequencer; the RAMs need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none
module iq_dc_clip_normalize
  import idcn_pkg::*;
#(
  parameter int MAX_BLOCK = 64
) (
  input  wire logic  clk,
  input  wire logic  rst,
  idcn_in_if.sink    in_ch,
  idcn_out_if.source out_ch
);

  localparam int AW = $clog2(MAX_BLOCK);
  localparam int CW = $clog2(MAX_BLOCK + 2);

  typedef enum logic [22:0] {
    S_LOAD   = 23'd1 << 0,
    S_MEAN   = 23'd1 << 1,
    S_CRD    = 23'd1 << 2,
    S_CSQ    = 23'd1 << 3,
    S_CWR    = 23'd1 << 4,
    S_SRT_RK = 23'd1 << 5,
    S_SRT_RJ = 23'd1 << 6,
    S_SRT_CM = 23'd1 << 7,
    S_MED_R1 = 23'd1 << 8,
    S_MED_R2 = 23'd1 << 9,
    S_MED_DN = 23'd1 << 10,
    S_DEV_R  = 23'd1 << 11,
    S_DEV_W  = 23'd1 << 12,
    S_CLP_R  = 23'd1 << 13,
    S_CLP_D  = 23'd1 << 14,
    S_CLP_W  = 23'd1 << 15,
    S_RMS_D  = 23'd1 << 16,
    S_RMS_S  = 23'd1 << 17,
    S_NRM_R  = 23'd1 << 18,
    S_NRM_D  = 23'd1 << 19,
    S_OUT    = 23'd1 << 20,
    S_ERR    = 23'd1 << 21,
    S_WAIT   = 23'd1 << 22
  } state_t;

  state_t state;

  logic [CW-1:0]              count;
  logic signed [SUM_W-1:0]    sum_re;
  logic signed [SUM_W-1:0]    sum_im;
  logic [ENERGY_W-1:0]        energy;
  logic signed [PART_W-1:0]   dc_re;
  logic signed [PART_W-1:0]   dc_im;
  logic [MAG_W-1:0]           median;
  logic                       mad_pass;
  logic [AW-1:0]              idx;
  logic [CW-1:0]              si;
  logic [AW-1:0]              sj;
  logic [MAG_W-1:0]           key;
  logic [MAG_W-1:0]           mid_lo;
  logic [MAG_W+3:0]           limit;
  logic [1:0]                 step;
  logic [1:0]                 status;
  logic                       err_pending;
  logic signed [PART_W-1:0]   cur_re;
  logic signed [PART_W-1:0]   cur_im;
  logic signed [PART_W-1:0]   res_re;
  logic [31:0]                rms;
  logic [15:0]                nrm_re;
  logic [15:0]                nrm_im;
  logic [15:0]                o_re;
  logic [15:0]                o_im;
  logic                       o_last;
  logic [1:0]                 o_status;
  logic                       o_valid;
  logic                       o_load;
  logic                       idx_clip;
  logic [MAG_W-1:0]           mag_clip;

  logic                 smp_we, mag_we, srt_we;
  logic [AW-1:0]        smp_addr, mag_addr, srt_addr;
  iq_part_t             smp_wdata, smp_rdata;
  logic [MAG_W-1:0]     mag_wdata, mag_rdata, srt_wdata, srt_rdata;

  div_req_t  dreq;
  div_rsp_t  drsp;
  sqrt_req_t qreq;
  sqrt_rsp_t qrsp;

  // Mean numerator 2*sum+n over 2n, negative sums rounded via magnitude.
  logic signed [SUM_W+1:0] mnum;
  logic [SUM_W+1:0]        mabs;
  logic                    mneg;
  logic [63:0]             mean_q;
  assign mnum   = (step <= 2'd1) ? ((SUM_W+2)'(sum_re) <<< 1) + (SUM_W+2)'(count)
                                 : ((SUM_W+2)'(sum_im) <<< 1) + (SUM_W+2)'(count);
  assign mneg   = mnum[SUM_W+1];
  assign mabs   = mneg ? (SUM_W+2)'(-mnum + (SUM_W+2)'({count, 1'b0}) - 1) : mnum;
  assign mean_q = mneg ? -drsp.quo : drsp.quo;

  logic mean_go;
  assign mean_go = (state == S_MEAN) && (step == 2'd0 || step == 2'd2);

  logic [63:0] mden;
  assign mden = 64'({count, 1'b0});

  // Merge the mean request into the divider port.
  div_req_t dreq_m;
  always_comb begin
    dreq_m = dreq;
    if (mean_go) begin
      dreq_m.start = 1'b1;
      dreq_m.num   = 64'(mabs);
      dreq_m.den   = mden;
    end
  end

  idcn_ram #(.WIDTH(2*PART_W), .DEPTH(MAX_BLOCK)) u_smp (
    .clk(clk), .we(smp_we), .addr(smp_addr), .wdata(smp_wdata), .rdata(smp_rdata));
  idcn_ram #(.WIDTH(MAG_W), .DEPTH(MAX_BLOCK)) u_mag (
    .clk(clk), .we(mag_we), .addr(mag_addr), .wdata(mag_wdata), .rdata(mag_rdata));
  idcn_ram #(.WIDTH(MAG_W), .DEPTH(MAX_BLOCK)) u_srt (
    .clk(clk), .we(srt_we), .addr(srt_addr), .wdata(srt_wdata), .rdata(srt_rdata));
  idcn_div  u_div  (.clk(clk), .rst(rst), .req(dreq_m), .rsp(drsp));
  idcn_sqrt u_sqrt (.clk(clk), .rst(rst), .req(qreq), .rsp(qrsp));

  logic in_fire, out_fire, full;
  logic signed [SAMPLE_W-1:0] ld_re, ld_im;
  logic [AW-1:0] nm1;
  logic [AW-1:0] half;
  logic signed [PART_W-1:0] cen_re, cen_im;
  logic signed [2*PART_W-1:0] sq_re, sq_im;
  logic signed [2*PART_W-1:0] sq_cre, sq_cim;
  logic [MAG_W-1:0] dev;
  logic [MAG_W-1:0] med_val;
  logic [PART_W-1:0] abs_cur;
  logic [MAG_W+3:0] mag_ext;
  logic [PART_W+MAG_W+3:0] clip_prod;
  logic [63:0] norm_q;
  logic        cur_neg;
  logic [16:0] sat_q;

  assign in_ch.ready = (state == S_LOAD) && !err_pending;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = o_valid && out_ch.ready;
  assign o_load      = ((state == S_OUT) || (state == S_ERR)) && (!o_valid || out_fire);
  assign full        = (count >= CW'(MAX_BLOCK));
  assign ld_re       = in_ch.sample_invalid ? 16'sd0 : in_ch.sample_re;
  assign ld_im       = in_ch.sample_invalid ? 16'sd0 : in_ch.sample_im;
  assign nm1         = AW'(count - CW'(1));
  assign half        = AW'(count >> 1);
  assign cen_re      = smp_rdata.re - dc_re;
  assign cen_im      = smp_rdata.im - dc_im;
  assign sq_cre      = cen_re * cen_re;
  assign sq_cim      = cen_im * cen_im;
  assign dev         = (mag_rdata > median) ? mag_rdata - median : median - mag_rdata;
  assign med_val     = count[0] ? srt_rdata
                                : MAG_W'(({1'b0, mid_lo} + {1'b0, srt_rdata}) >> 1);
  assign abs_cur     = (step == 2'd0) ? PART_W'(cur_re < 0 ? -cur_re : cur_re)
                                      : PART_W'(cur_im < 0 ? -cur_im : cur_im);
  assign mag_ext     = {4'b0, mag_rdata};
  assign clip_prod   = abs_cur * limit;
  assign norm_q      = drsp.quo;
  // Negative parts saturate at -32768, positive parts at 32767.
  assign cur_neg     = (step == 2'd0) ? (cur_re < 0) : (cur_im < 0);
  assign sat_q       = cur_neg ? ((norm_q > 64'd32768) ? 17'd32768 : norm_q[16:0])
                               : ((norm_q > 64'd32767) ? 17'd32767 : norm_q[16:0]);

  // Memory port addressing and write data, one access per RAM a cycle.
  always_comb begin
    smp_we    = 1'b0;
    mag_we    = 1'b0;
    srt_we    = 1'b0;
    smp_addr  = idx;
    mag_addr  = idx;
    srt_addr  = idx;
    smp_wdata = '{im: cur_im, re: cur_re};
    mag_wdata = qrsp.root[MAG_W-1:0];
    srt_wdata = qrsp.root[MAG_W-1:0];
    sq_re     = cur_re * cur_re;
    sq_im     = cur_im * cur_im;
    unique case (state)
      S_LOAD: begin
        smp_we    = in_fire && !full;
        smp_addr  = AW'(count);
        smp_wdata = '{im: PART_W'(ld_im), re: PART_W'(ld_re)};
      end
      S_CWR: begin
        smp_we = qrsp.done;
        mag_we = qrsp.done;
        srt_we = qrsp.done;
      end
      S_SRT_RK: srt_addr = AW'(si);
      S_SRT_RJ: srt_addr = AW'(sj - AW'(1));
      S_SRT_CM: begin
        srt_we    = 1'b1;
        srt_addr  = sj;
        srt_wdata = (sj != '0 && srt_rdata > key) ? srt_rdata : key;
      end
      S_MED_R1: srt_addr = (count[0]) ? half : AW'(half - AW'(1));
      S_MED_R2: srt_addr = half;
      S_DEV_W: begin
        srt_we    = 1'b1;
        srt_wdata = dev;
      end
      S_CLP_W: smp_we = 1'b1;
      default: ;
    endcase
  end

  // Requests to the shared divider and root unit.
  always_comb begin
    dreq = '0;
    qreq = '0;
    unique case (state)
      S_CSQ: begin
        qreq.start = 1'b1;
        qreq.arg   = 64'(sq_cre) + 64'(sq_cim);
      end
      S_CLP_R: begin
        if (!step[1] && idx_clip) begin
          dreq.start = 1'b1;
          dreq.num   = 64'(clip_prod);
          dreq.den   = 64'(mag_clip);
        end
      end
      S_RMS_D: begin
        if (step == 2'd0) begin
          dreq.start = 1'b1;
          dreq.num   = {6'd0, energy, 16'd0};
          dreq.den   = 64'(count);
        end
      end
      S_RMS_S: begin
        if (step == 2'd0) begin
          qreq.start = 1'b1;
          qreq.arg   = drsp.quo;
        end
      end
      S_NRM_R: begin
        if (!step[1]) begin
          dreq.start = 1'b1;
          dreq.num   = (64'(abs_cur) << 19) + 64'(rms >> 1);
          dreq.den   = 64'(rms);
        end
      end
      default: ;
    endcase
  end

  // Block sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      count       <= '0;
      sum_re      <= '0;
      sum_im      <= '0;
      energy      <= '0;
      err_pending <= 1'b0;
      o_valid     <= 1'b0;
      step        <= '0;
      mad_pass    <= 1'b0;
    end else begin
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (out_fire) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (!full) begin
              count  <= count + CW'(1);
              sum_re <= sum_re + SUM_W'(ld_re);
              sum_im <= sum_im + SUM_W'(ld_im);
            end else begin
              count <= CW'(MAX_BLOCK + 1);
            end
            if (in_ch.last_sample) begin
              if (full) begin
                status <= STATUS_ARG_ERR;
                state  <= S_ERR;
              end else begin
                step   <= 2'd0;
                state  <= S_MEAN;
              end
            end
          end
        end
        // Rounded mean per part through the divider: sign handled by bias.
        S_MEAN: begin
          if (step == 2'd0) begin
            step <= 2'd1;
          end else if (step == 2'd1 && drsp.done) begin
            dc_re <= PART_W'(mean_q);
            step  <= 2'd2;
          end else if (step == 2'd3 && drsp.done) begin
            dc_im <= PART_W'(mean_q);
            idx   <= '0;
            state <= S_CRD;
          end else if (step == 2'd2) begin
            step <= 2'd3;
          end
        end
        S_CRD: state <= S_CSQ;
        S_CSQ: begin
          cur_re <= cen_re;
          cur_im <= cen_im;
          state  <= S_CWR;
        end
        S_CWR: begin
          if (qrsp.done) begin
            if (idx == nm1) begin
              si       <= CW'(1);
              mad_pass <= 1'b0;
              state    <= (count == CW'(1)) ? S_MED_R1 : S_SRT_RK;
            end else begin
              idx   <= idx + AW'(1);
              state <= S_CRD;
            end
          end
        end
        // Insertion sort: hold key, shift larger entries up one.
        S_SRT_RK: begin
          sj    <= AW'(si);
          state <= S_SRT_RJ;
          step  <= 2'd1;
        end
        S_SRT_RJ: begin
          if (step == 2'd1) begin
            key <= srt_rdata;
          end
          step  <= 2'd0;
          state <= S_SRT_CM;
        end
        S_SRT_CM: begin
          if (sj != '0 && srt_rdata > key) begin
            sj    <= sj - AW'(1);
            state <= S_SRT_RJ;
          end else if (si == count - CW'(1)) begin
            state <= S_MED_R1;
          end else begin
            si    <= si + CW'(1);
            state <= S_SRT_RK;
          end
        end
        S_MED_R1: state <= S_MED_R2;
        S_MED_R2: begin
          mid_lo <= srt_rdata;
          state  <= S_MED_DN;
        end
        S_MED_DN: begin
          if (!mad_pass) begin
            median   <= med_val;
            mad_pass <= 1'b1;
            idx      <= '0;
            state    <= S_DEV_R;
          end else begin
            limit  <= (MAG_W+4)'(median) + ((MAG_W+4)'(med_val) << 3);
            idx    <= '0;
            energy <= '0;
            step   <= 2'd3;
            state  <= S_CLP_R;
          end
        end
        S_DEV_R: state <= S_DEV_W;
        S_DEV_W: begin
          if (idx == nm1) begin
            si    <= CW'(1);
            state <= (count == CW'(1)) ? S_MED_R1 : S_SRT_RK;
          end else begin
            idx   <= idx + AW'(1);
            state <= S_DEV_R;
          end
        end
        // Clip each part by limit/magnitude, then accumulate energy.
        S_CLP_R: begin
          if (step == 2'd3) begin
            step <= 2'd2;
          end else if (step == 2'd2) begin
            cur_re   <= smp_rdata.re;
            cur_im   <= smp_rdata.im;
            idx_clip <= (mag_ext > limit) && (mag_rdata != '0);
            mag_clip <= mag_rdata;
            step     <= 2'd0;
          end else if (!idx_clip) begin
            state <= S_CLP_W;
          end else begin
            state <= S_CLP_D;
          end
        end
        S_CLP_D: begin
          if (drsp.done) begin
            if (step == 2'd0) begin
              res_re <= (cur_re < 0) ? -PART_W'(drsp.quo) : PART_W'(drsp.quo);
              step   <= 2'd1;
              state  <= S_CLP_R;
            end else begin
              cur_re <= res_re;
              cur_im <= (cur_im < 0) ? -PART_W'(drsp.quo) : PART_W'(drsp.quo);
              state  <= S_CLP_W;
            end
          end
        end
        S_CLP_W: begin
          energy <= energy + ENERGY_W'(sq_re) + ENERGY_W'(sq_im);
          if (idx == nm1) begin
            step  <= 2'd0;
            state <= S_RMS_D;
          end else begin
            idx   <= idx + AW'(1);
            step  <= 2'd3;
            state <= S_CLP_R;
          end
        end
        S_RMS_D: begin
          if (step == 2'd0) begin
            if (energy == '0) begin
              status <= STATUS_DATA_ERR;
              state  <= S_ERR;
            end else begin
              step <= 2'd1;
            end
          end else if (drsp.done) begin
            step  <= 2'd0;
            state <= S_RMS_S;
          end
        end
        S_RMS_S: begin
          if (step == 2'd0) begin
            step <= 2'd1;
          end else if (qrsp.done) begin
            rms   <= qrsp.root;
            idx   <= '0;
            step  <= 2'd3;
            state <= (qrsp.root == '0) ? S_ERR : S_NRM_R;
            status <= STATUS_DATA_ERR;
          end
        end
        // Normalize each part by the RMS and hold it until the output is free.
        S_NRM_R: begin
          if (step == 2'd3) begin
            step <= 2'd2;
          end else if (step == 2'd2) begin
            cur_re <= smp_rdata.re;
            cur_im <= smp_rdata.im;
            step   <= 2'd0;
          end else begin
            state <= S_NRM_D;
          end
        end
        S_NRM_D: begin
          if (drsp.done) begin
            if (step == 2'd0) begin
              nrm_re <= cur_neg ? 16'(-sat_q) : 16'(sat_q);
              step   <= 2'd1;
              state  <= S_NRM_R;
            end else begin
              nrm_im <= cur_neg ? 16'(-sat_q) : 16'(sat_q);
              state  <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!o_valid || out_fire) begin
            o_re     <= nrm_re;
            o_im     <= nrm_im;
            o_status <= STATUS_OK;
            o_last   <= (idx == nm1);
            if (idx == nm1) begin
              count  <= '0;
              sum_re <= '0;
              sum_im <= '0;
              state  <= S_WAIT;
            end else begin
              idx   <= idx + AW'(1);
              step  <= 2'd3;
              state <= S_NRM_R;
            end
          end
        end
        S_ERR: begin
          if (!o_valid || out_fire) begin
            o_re     <= '0;
            o_im     <= '0;
            o_status <= status;
            o_last   <= 1'b1;
            count    <= '0;
            sum_re   <= '0;
            sum_im   <= '0;
            state    <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (!o_valid || out_fire) begin
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign out_ch.valid    = o_valid;
  assign out_ch.out_re   = o_re;
  assign out_ch.out_im   = o_im;
  assign out_ch.status   = o_status;
  assign out_ch.last_out = o_last;

  // The input is closed whenever a block is being worked on.
  a_closed: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> !in_ch.ready) else $error("input open while busy");
  // An error result is always a single, final transaction.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_status != STATUS_OK) |-> o_last) else $error("error not last");
  // The count never runs past the overflow mark.
  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_BLOCK + 1)) else $error("count overflow");

endmodule : iq_dc_clip_normalize
`default_nettype wire

[bench/tb_iq_dc_clip_normalize.sv]
// ----------------------------------------------------------------------------
// tb_iq_dc_clip_normalize: self-checking bench for the I/Q normalization block
//
// Blocks of samples are queued by a stimulus process and driven by a clocked
// driver with random gaps. Each accepted sample is passed to a predictor that
// does DC removal, MAD clipping and RMS scaling. The predictor queues the
// normalized samples it expects. A clocked monitor applies random stalls and
// checks every result transaction against the oldest expected sample.
// ----------------------------------------------------------------------------
module tb_iq_dc_clip_normalize
  import idcn_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BLOCK = 64;

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               invalid;
    logic               last;
  } sample_t;

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic [1:0]         status;
    logic               last;
  } norm_t;

  logic clk;
  logic rst;

  idcn_in_if  in_ch ();
  idcn_out_if out_ch ();

  iq_dc_clip_normalize #(.MAX_BLOCK(MAX_BLOCK)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sample_t pending_samples[$];
  norm_t   expected_norm[$];
  int      error_count = 0;

  // Samples of the block being collected by the predictor.
  longint blk_re[$];
  longint blk_im[$];
  bit     blk_overflow = 0;

  // Clock generation.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Prints one mismatch line and counts it.
  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Integer square root, bit by bit.
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Median of a list; for an even count the floor of the middle pair mean.
  function automatic longint median_of(input longint vals[$]);
    longint key;
    int     j;
    int     n;
    n = vals.size();
    for (int i = 1; i < n; i++) begin
      key = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > key) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = key;
    end
    if (n % 2 == 1) return vals[n/2];
    return (vals[n/2-1] + vals[n/2]) >>> 1;
  endfunction

  // Divides one part by the RMS with rounding, then saturates.
  function automatic logic signed [15:0] scale_part(input longint x, input longint r);
    longint a;
    longint q;
    a = (x < 0) ? -x : x;
    q = ((a << 19) + (r >>> 1)) / r;
    if (x < 0) begin
      if (q > 32768) q = 32768;
      return 16'(-q);
    end
    if (q > 32767) q = 32767;
    return 16'(q);
  endfunction

  task automatic push_single(input logic [1:0] status);
    norm_t e;
    e.re = '0;
    e.im = '0;
    e.status = status;
    e.last = 1'b1;
    expected_norm.push_back(e);
  endtask

  // Takes one accepted sample; at the end of a block predicts its results.
  task automatic absorb_sample(input sample_t s);
    longint re, im, sum_re, sum_im, num, den, dc_re, dc_im;
    longint mags[$];
    longint devs[$];
    longint cre[$];
    longint cim[$];
    longint median, mad, limit, energy, r, a;
    int     n;
    norm_t  e;
    re = s.invalid ? 0 : longint'(s.re);
    im = s.invalid ? 0 : longint'(s.im);
    if (blk_re.size() < MAX_BLOCK) begin
      blk_re.push_back(re);
      blk_im.push_back(im);
    end else begin
      blk_overflow = 1;
    end
    if (!s.last) return;
    if (blk_overflow) begin
      push_single(STATUS_ARG_ERR);
    end else begin
      n = blk_re.size();
      sum_re = 0;
      sum_im = 0;
      foreach (blk_re[i]) begin
        sum_re += blk_re[i];
        sum_im += blk_im[i];
      end
      // Block mean, rounded half up.
      den = 2 * n;
      num = 2 * sum_re + n;
      dc_re = (num >= 0) ? num / den : -((-num + den - 1) / den);
      num = 2 * sum_im + n;
      dc_im = (num >= 0) ? num / den : -((-num + den - 1) / den);
      foreach (blk_re[i]) begin
        cre.push_back(blk_re[i] - dc_re);
        cim.push_back(blk_im[i] - dc_im);
        mags.push_back(longint'(int_sqrt(cre[i] * cre[i] + cim[i] * cim[i])));
      end
      median = median_of(mags);
      foreach (mags[i]) devs.push_back(mags[i] > median ? mags[i] - median : median - mags[i]);
      mad = median_of(devs);
      limit = median + 8 * mad;
      // Clip outliers and total the energy.
      energy = 0;
      for (int i = 0; i < n; i++) begin
        if (mags[i] > limit && mags[i] > 0) begin
          a = (cre[i] < 0) ? -cre[i] : cre[i];
          cre[i] = (cre[i] < 0) ? -(a * limit / mags[i]) : a * limit / mags[i];
          a = (cim[i] < 0) ? -cim[i] : cim[i];
          cim[i] = (cim[i] < 0) ? -(a * limit / mags[i]) : a * limit / mags[i];
        end
        energy += cre[i] * cre[i] + cim[i] * cim[i];
      end
      r = (energy == 0) ? 0 : longint'(int_sqrt(longint'((energy << 16) / n)));
      if (r == 0) begin
        push_single(STATUS_DATA_ERR);
      end else begin
        for (int i = 0; i < n; i++) begin
          e.re = scale_part(cre[i], r);
          e.im = scale_part(cim[i], r);
          e.status = STATUS_OK;
          e.last = (i == n - 1);
          expected_norm.push_back(e);
        end
      end
    end
    blk_re.delete();
    blk_im.delete();
    blk_overflow = 0;
  endtask

  // Gap length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Input driver.
  int in_gap  = 0;
  int in_calm = 0;
  always @(posedge clk) begin
    sample_t s;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        s.re = in_ch.sample_re;
        s.im = in_ch.sample_im;
        s.invalid = in_ch.sample_invalid;
        s.last = in_ch.last_sample;
        absorb_sample(s);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          s = pending_samples.pop_front();
          in_ch.valid          <= 1'b1;
          in_ch.sample_re      <= s.re;
          in_ch.sample_im      <= s.im;
          in_ch.sample_invalid <= s.invalid;
          in_ch.last_sample    <= s.last;
          if (in_calm > 0) begin
            in_calm--;
          end else begin
            in_gap = pick_gap();
            if ($urandom_range(0, 19) == 0) in_calm = $urandom_range(20, 60);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor with random stalls.
  int out_gap  = 0;
  int out_calm = 0;
  always @(posedge clk) begin
    norm_t e;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_norm.size() == 0) begin
          report($sformatf("unexpected result re=%0d im=%0d status=%0d",
                           out_ch.out_re, out_ch.out_im, out_ch.status));
        end else begin
          e = expected_norm.pop_front();
          if (out_ch.out_re !== e.re)
            report($sformatf("out_re %0d, expected %0d", out_ch.out_re, e.re));
          if (out_ch.out_im !== e.im)
            report($sformatf("out_im %0d, expected %0d", out_ch.out_im, e.im));
          if (out_ch.status !== e.status)
            report($sformatf("status %0d, expected %0d", out_ch.status, e.status));
          if (out_ch.last_out !== e.last)
            report($sformatf("last_out %0b, expected %0b", out_ch.last_out, e.last));
        end
      end
      if (out_calm > 0) begin
        out_calm--;
        out_ch.ready <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        out_gap = pick_gap();
        if ($urandom_range(0, 19) == 0) out_calm = $urandom_range(20, 60);
      end
    end
  end

  task automatic add_sample(input int re, input int im, input bit inv, input bit last);
    sample_t s;
    s.re = 16'(re);
    s.im = 16'(im);
    s.invalid = inv;
    s.last = last;
    pending_samples.push_back(s);
  endtask

  // Stimulus.
  initial begin
    int items, n, dc_re, dc_im, amp, kind;
    bit did_full, did_over;
    in_ch.valid = 1'b0;
    in_ch.sample_re = '0;
    in_ch.sample_im = '0;
    in_ch.sample_invalid = 1'b0;
    in_ch.last_sample = 1'b0;
    out_ch.ready = 1'b0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // A one-sample block centers to zero energy.
    add_sample(32767, -32768, 0, 1);
    // Two opposite extremes.
    add_sample(32767, 32767, 0, 0);
    add_sample(-32768, -32768, 0, 1);
    // Invalid sample inside a block.
    add_sample(100, 200, 0, 0);
    add_sample(1, 1, 1, 0);
    add_sample(-32768, 32767, 0, 0);
    add_sample(5, -7, 0, 1);
    // Identical samples give zero energy.
    add_sample(1234, -4321, 0, 0);
    add_sample(1234, -4321, 0, 0);
    add_sample(1234, -4321, 0, 1);
    // Tight cluster with one large outlier that is clipped.
    for (int i = 0; i < 7; i++) add_sample(1000 + i * 3, -500 + i, 0, 0);
    add_sample(30000, -30000, 0, 1);
    // All samples invalid.
    add_sample(7, 7, 1, 0);
    add_sample(-9, 3, 1, 0);
    add_sample(32767, 32767, 1, 1);
    items = 21;

    // One full block and one overflowing block first, then short blocks.
    did_full = 0;
    did_over = 0;
    while (items < 170) begin
      if (!did_full) begin
        n = MAX_BLOCK;
        did_full = 1;
      end else if (!did_over) begin
        n = MAX_BLOCK + $urandom_range(1, 3);
        did_over = 1;
      end else begin
        n = $urandom_range(1, 10);
      end
      dc_re = $urandom_range(0, 40000) - 20000;
      dc_im = $urandom_range(0, 40000) - 20000;
      amp = 1 << $urandom_range(0, 12);
      for (int i = 0; i < n; i++) begin
        kind = $urandom_range(0, 99);
        if (kind < 20) begin
          add_sample($urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 19) == 0, i == n - 1);
        end else if (kind < 28) begin
          add_sample($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                     0, i == n - 1);
        end else begin
          add_sample(dc_re + $urandom_range(0, 2 * amp) - amp,
                     dc_im + $urandom_range(0, 2 * amp) - amp,
                     $urandom_range(0, 29) == 0, i == n - 1);
        end
      end
      items += n;
    end

    wait (pending_samples.size() == 0 && !in_ch.valid && expected_norm.size() == 0);
    repeat (300) @(posedge clk);
    if (error_count == 0) begin
      $display("iq_dc_clip_normalize test passed");
    end else begin
      $display("iq_dc_clip_normalize test failed");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #20ms;
    $display("iq_dc_clip_normalize test failed");
    $finish;
  end

endmodule
